// ===== rtl/core/fopa_pkg.sv =====
// types, codes and command/status structs shared by the pool allocator modules
package fopa_pkg;

  localparam int HANDLE_W    = 8;
  localparam int QUEUE_DEPTH = 1 << HANDLE_W;
  localparam int COUNT_W     = HANDLE_W + 1;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [1:0]          opcode_t;
  typedef logic [1:0]          result_t;

  // request kinds
  localparam opcode_t OP_ALLOC = 2'd0;
  localparam opcode_t OP_TRY   = 2'd1;
  localparam opcode_t OP_FREE  = 2'd2;

  // result codes
  localparam result_t RES_OK        = 2'd0;
  localparam result_t RES_NONE_FREE = 2'd1;
  localparam result_t RES_POOL_FULL = 2'd2;
  localparam result_t RES_INVALID   = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    pop;
    logic    mint;
    logic    push;
    logic    emit;
    result_t code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    queue_empty;
    logic    queue_full;
    logic    pool_full;
    logic    map_hit;
  } stat_t;

endpackage

// ===== rtl/core/fopa_ctrl.sv =====
// controller: request sequencing and outcome decision
module fopa_ctrl
  import fopa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = start;
      end
      ST_EXEC: begin
        busy     = 1'b1;
        cmd.emit = 1'b1;
        cmd.code = RES_OK;
        case (stat.op)
          OP_ALLOC: begin
            if (!stat.queue_empty) begin
              cmd.pop = 1'b1;
            end else if (!stat.pool_full) begin
              cmd.mint = 1'b1;
            end else begin
              cmd.code = RES_POOL_FULL;
            end
          end
          OP_TRY: begin
            if (!stat.queue_empty) begin
              cmd.pop = 1'b1;
            end else begin
              cmd.code = RES_NONE_FREE;
            end
          end
          OP_FREE: begin
            // a full queue drops the push but the bit is still cleared
            if (stat.map_hit) begin
              cmd.push = !stat.queue_full;
            end else begin
              cmd.code = RES_INVALID;
            end
          end
          default: begin
            cmd.code = RES_INVALID;
          end
        endcase
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/fopa_datapath.sv =====
// datapath: free queue memory, pointers, mint counter and in-use bitmap
module fopa_datapath
  import fopa_pkg::*;
#(
  parameter int POOL_SIZE = 256
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  input  opcode_t in_opcode,
  input  handle_t in_free_handle,
  output stat_t   stat,
  output logic    out_valid,
  output handle_t out_given_handle,
  output result_t out_status
);

  localparam int     LIMIT_INT = (POOL_SIZE < QUEUE_DEPTH) ? POOL_SIZE : QUEUE_DEPTH;
  localparam count_t POOL_LIMIT = count_t'(LIMIT_INT);

  handle_t mem [QUEUE_DEPTH];
  handle_t rd_data_r;

  opcode_t op_r;
  handle_t fh_r;
  handle_t head_r;
  handle_t tail_r;
  count_t  count_r;
  count_t  minted_r;
  logic [QUEUE_DEPTH-1:0] map_r;

  logic    out_valid_r;
  handle_t given_r;
  result_t status_r;
  handle_t given_nxt;

  // head entry is read every cycle, so it is ready once a request is taken
  always_ff @(posedge clk) begin
    rd_data_r <= mem[head_r];
    if (cmd.push) mem[tail_r] <= fh_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_opcode;
      fh_r <= in_free_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      minted_r <= '0;
      map_r    <= '0;
    end else begin
      if (cmd.pop) begin
        head_r           <= head_r + 1'b1;
        count_r          <= count_r - 1'b1;
        map_r[rd_data_r] <= 1'b1;
      end
      if (cmd.mint) begin
        minted_r                  <= minted_r + 1'b1;
        map_r[minted_r[HANDLE_W-1:0]] <= 1'b1;
      end
      if (cmd.emit && op_r == OP_FREE && map_r[fh_r]) begin
        map_r[fh_r] <= 1'b0;
      end
      if (cmd.push) begin
        tail_r  <= tail_r + 1'b1;
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_comb begin
    given_nxt = '0;
    if (cmd.pop) begin
      given_nxt = rd_data_r;
    end else if (cmd.mint) begin
      given_nxt = minted_r[HANDLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      given_r  <= given_nxt;
      status_r <= cmd.code;
    end
  end

  assign stat.op          = op_r;
  assign stat.queue_empty = (count_r == '0);
  assign stat.queue_full  = count_r[HANDLE_W];
  assign stat.pool_full   = (minted_r >= POOL_LIMIT);
  assign stat.map_hit     = map_r[fh_r];

  assign out_valid        = out_valid_r;
  assign out_given_handle = given_r;
  assign out_status       = status_r;

endmodule

// ===== rtl/core/fifo_object_pool_allocator_unit.sv =====
// top level of the fifo object pool allocator: handle pool with a fifo free list
//
//  channel   ports                                   transfer when
//  -------   -------------------------------------   -----------------------
//  request   start, busy, in_opcode, in_free_handle  start high, busy low
//  result    out_valid, out_given_handle, out_status out_valid high (1 cycle)
//
// each request has a transfer edge, which also registers the free queue head
// entry out of the queue memory, and an execute cycle, which decides the
// outcome and updates pointers, bitmap and mint counter
// the result strobe shows in the cycle after execute, where busy is low again,
// so a new request may transfer while the previous result is on the ports
// synchronous reset clears pointers, counts, the in-use bitmap and control
// state; queue memory contents are left as they are
// the receiver cannot stall: every result is taken in its strobe cycle
module fifo_object_pool_allocator_unit
  import fopa_pkg::*;
#(
  parameter int POOL_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_free_handle,
  output logic       out_valid,
  output logic [7:0] out_given_handle,
  output logic [1:0] out_status
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing and outcome choice
  fopa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // storage and result registers
  fopa_datapath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_opcode),
    .in_free_handle   (in_free_handle),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_given_handle (out_given_handle),
    .out_status       (out_status)
  );

  // a taken request yields its result once the execute state is over
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result strobe missing after request transfer");

  // results never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // at most one pool action per request
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.pop, cmd.mint, cmd.push}))
    else $error("more than one pool action at once");

  // a pop never hits an empty queue, a mint never passes the bound
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.pop || !stat.queue_empty) && (!cmd.mint || !stat.pool_full))
    else $error("pop on empty queue or mint past pool bound");

endmodule

// ===== bench/fopa_grant_checker.sv =====
`timescale 1ns / 100ps
// checker for the pool allocator: predicts each grant or release and compares results
module fopa_grant_checker
  import fopa_pkg::*;
#(
  parameter int POOL_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_free_handle,
  input  logic       out_valid,
  input  logic [7:0] out_given_handle,
  input  logic [1:0] out_status,
  output int         fail_count,
  output int         pending
);

  // handles are 8 bits, so minting stops at the handle space at most
  localparam int MINT_CAP = (POOL_SIZE < QUEUE_DEPTH) ? POOL_SIZE : QUEUE_DEPTH;

  typedef struct {
    handle_t handle;
    result_t code;
  } grant_t;

  grant_t                 expected_grants[$];
  handle_t                freed_handles[$];
  logic [QUEUE_DEPTH-1:0] handle_in_use;
  count_t                 minted_handles;

  initial begin
    fail_count     = 0;
    pending        = 0;
    minted_handles = '0;
    handle_in_use  = '0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic model_pool_request(input opcode_t op, input handle_t fh);
    grant_t g;
    g.handle = '0;
    g.code   = RES_OK;
    case (op)
      OP_ALLOC, OP_TRY: begin
        if (freed_handles.size() != 0) begin
          g.handle = freed_handles.pop_front();
          handle_in_use[g.handle] = 1'b1;
        end else if (op == OP_TRY) begin
          g.code = RES_NONE_FREE;
        end else if (minted_handles < MINT_CAP) begin
          g.handle = minted_handles[HANDLE_W-1:0];
          minted_handles++;
          handle_in_use[g.handle] = 1'b1;
        end else begin
          g.code = RES_POOL_FULL;
        end
      end
      OP_FREE: begin
        if (handle_in_use[fh]) begin
          handle_in_use[fh] = 1'b0;
          if (freed_handles.size() < QUEUE_DEPTH) freed_handles.push_back(fh);
        end else begin
          g.code = RES_INVALID;
        end
      end
      default: g.code = RES_INVALID;
    endcase
    expected_grants.push_back(g);
  endtask

  // results are checked before the request of the same edge is modeled
  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      expected_grants.delete();
      freed_handles.delete();
      handle_in_use  = '0;
      minted_handles = '0;
    end else begin
      if (out_valid) begin
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: handle %0d status %0d",
                                    out_given_handle, out_status));
        end else begin
          g = expected_grants.pop_front();
          if (out_given_handle !== g.handle)
            report_mismatch($sformatf("given_handle %0d, expected %0d",
                                      out_given_handle, g.handle));
          if (out_status !== g.code)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, g.code));
        end
      end
      if (start && !busy) model_pool_request(in_opcode, in_free_handle);
    end
    pending = expected_grants.size();
  end

endmodule

// ===== bench/fifo_object_pool_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the pool allocator: stimulus, watchdog and verdict
module fifo_object_pool_allocator_unit_tb;
  import fopa_pkg::*;

  localparam int POOL_SIZE   = 256;
  // cycles with no transfer on either channel before the run is given up
  localparam int STALL_LIMIT = 2000;
  // the one opcode value with no request kind behind it
  localparam opcode_t OP_UNUSED = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_opcode = OP_ALLOC;
  logic [7:0] in_free_handle = '0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_given_handle;
  logic [1:0] out_status;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  // chance in percent that the request side sits out a cycle
  int send_idle_pct = 0;
  // allocate and try requests issued, an upper bound on handles handed out
  int allocs_sent = 0;

  always #5 clk = ~clk;

  fifo_object_pool_allocator_unit #(
    .POOL_SIZE(POOL_SIZE)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_free_handle  (in_free_handle),
    .out_valid       (out_valid),
    .out_given_handle(out_given_handle),
    .out_status      (out_status)
  );

  fopa_grant_checker #(
    .POOL_SIZE(POOL_SIZE)
  ) grant_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_free_handle  (in_free_handle),
    .out_valid       (out_valid),
    .out_given_handle(out_given_handle),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // watchdog: any request or result transfer restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("fifo_object_pool_allocator_unit_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request transfer; start stays high after the transfer so back to back
  // requests never drop it, the next call lowers it only for an idle gap
  task automatic send_request(input opcode_t op, input handle_t fh);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start          = 1'b1;
    in_opcode      = op;
    in_free_handle = fh;
    if (op == OP_ALLOC || op == OP_TRY) allocs_sent++;
    // busy is read at the edge before the block updates it
    do @(posedge clk); while (busy);
  endtask

  // weighted random request; what is left of 100 goes to the unused opcode
  task automatic random_request(input int alloc_w, input int try_w, input int free_w);
    int      roll;
    int      span;
    handle_t fh;
    roll = $urandom_range(99);
    span = (allocs_sent > 255) ? 255 : allocs_sent;
    // frees mostly aim at handles that may be out, the rest anywhere
    fh = ($urandom_range(3) != 0) ? handle_t'($urandom_range(span))
                                  : handle_t'($urandom_range(255));
    if (roll < alloc_w)
      send_request(OP_ALLOC, handle_t'($urandom_range(255)));
    else if (roll < alloc_w + try_w)
      send_request(OP_TRY, handle_t'($urandom_range(255)));
    else if (roll < alloc_w + try_w + free_w)
      send_request(OP_FREE, fh);
    else
      send_request(OP_UNUSED, handle_t'($urandom_range(255)));
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // request side idles often, results can never be held off
    send_idle_pct = 31;

    // directed: empty pool, invalid frees, unused opcode
    send_request(OP_TRY, 8'hff);
    send_request(OP_FREE, 8'h00);
    send_request(OP_FREE, 8'hff);
    send_request(OP_UNUSED, 8'haa);
    // mint a few, free out of order, double free
    send_request(OP_ALLOC, 8'h00);
    send_request(OP_ALLOC, 8'hff);
    send_request(OP_ALLOC, 8'h55);
    send_request(OP_FREE, 8'h01);
    send_request(OP_FREE, 8'h01);
    send_request(OP_FREE, 8'h00);
    // reuse comes oldest first, then minting resumes
    send_request(OP_TRY, 8'h00);
    send_request(OP_ALLOC, 8'h00);
    send_request(OP_ALLOC, 8'h00);
    send_request(OP_FREE, 8'h02);
    send_request(OP_FREE, 8'h03);
    send_request(OP_TRY, 8'h00);
    send_request(OP_TRY, 8'h00);
    send_request(OP_TRY, 8'h00);
    send_request(OP_UNUSED, 8'h55);

    // allocate heavy: mints the whole pool and runs into pool full
    repeat (350) random_request(85, 5, 8);

    // free heavy with long gaps: frees refill the free fifo, try drains it
    send_idle_pct = 73;
    repeat (250) random_request(25, 20, 50);

    // balanced, back to back
    send_idle_pct = 0;
    repeat (300) random_request(55, 15, 27);

    @(negedge clk);
    start = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("fifo_object_pool_allocator_unit_tb passed");
    else
      $display("fifo_object_pool_allocator_unit_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fopa_pkg.sv
rtl/core/fopa_ctrl.sv
rtl/core/fopa_datapath.sv
rtl/core/fifo_object_pool_allocator_unit.sv
bench/fopa_grant_checker.sv
bench/fifo_object_pool_allocator_unit_tb.sv
